### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the top-level RTL file of the core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("Assertion failed: same-cycle implication violated.");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("Assertion failed: next-cycle implication violated.");

`endif

### rtl/core/xs128_pkg.sv
// ----------------------------------------------------------------------------
// xs128_pkg
// Types, constants and functions shared by the xorshift128 generator modules.
// ----------------------------------------------------------------------------
package xs128_pkg;

    localparam int unsigned WORD_W = 32;

    localparam logic OP_NEXT   = 1'b0;
    localparam logic OP_RESEED = 1'b1;

    localparam logic [WORD_W-1:0] RESET_WORD_A = 32'd123456789;
    localparam logic [WORD_W-1:0] RESET_WORD_B = 32'd362436069;
    localparam logic [WORD_W-1:0] RESET_WORD_C = 32'd521288629;
    localparam logic [WORD_W-1:0] RESET_WORD_D = 32'd88675123;

    localparam logic [WORD_W-1:0] SEED_MULT = 32'd1812433253;
    localparam logic [WORD_W-1:0] SEED_KA   = 32'd123464980;
    localparam logic [WORD_W-1:0] SEED_KB   = 32'd3447902351;
    localparam logic [WORD_W-1:0] SEED_KC   = 32'd2859490775;
    localparam logic [WORD_W-1:0] SEED_KD   = 32'd47621719;

    localparam logic [1:0] LAST_WORD_IDX = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_MIX
    } state_t;

    typedef struct packed {
        logic       load_seed;
        logic       mul_en;
        logic       mix_en;
        logic       next_en;
        logic [1:0] key_idx;
    } dp_cmd_t;

    typedef struct packed {
        logic all_zero;
    } dp_status_t;

    function automatic logic [WORD_W-1:0] seed_key(input logic [1:0] idx);
        logic [WORD_W-1:0] key;
        case (idx)
            2'd0:    key = SEED_KA;
            2'd1:    key = SEED_KB;
            2'd2:    key = SEED_KC;
            default: key = SEED_KD;
        endcase
        return key;
    endfunction

    function automatic logic [WORD_W-1:0] seed_mix(input logic [WORD_W-1:0] s);
        logic [WORD_W-1:0] v;
        v = s ^ (s << 13);
        v = v ^ (v >> 17);
        return v;
    endfunction

endpackage

### rtl/core/xorshift128_generator_with_seeding_unit.sv
// ----------------------------------------------------------------------------
// xorshift128_generator_with_seeding_unit
// A next transaction computes the new word at acceptance and holds it in an
// output register, and the next transaction is taken in the following cycle
// if that word is taken or the register is empty. A reseed transaction
// returns no word and passes each state word through the registered seed
// multiplier (ST_MUL) and then the xor-shift mix (ST_MIX); the unit is busy
// until all four words are done, and runs a second expansion when the first
// expansion gives four zero words.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module xorshift128_generator_with_seeding_unit
    import xs128_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              operation,
    input  logic [WORD_W-1:0] seed_value,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [WORD_W-1:0] random_word
);

    dp_cmd_t    cmd;
    dp_status_t status;

    xs128_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .operation (operation),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    xs128_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .seed_value  (seed_value),
        .status      (status),
        .random_word (random_word)
    );

    `ASSERT_NEXT(a_reseed_busy, clk, rst_n, in_valid && in_ready && operation == OP_RESEED, !in_ready && cmd.mul_en)
    `ASSERT_NEXT(a_next_result, clk, rst_n, in_valid && in_ready && operation == OP_NEXT, out_valid)
    `ASSERT_IMPL(a_cmd_excl, clk, rst_n, cmd.mix_en || cmd.mul_en, !cmd.next_en && !cmd.load_seed)

endmodule

### rtl/core/xs128_ctrl.sv
// ----------------------------------------------------------------------------
// xs128_ctrl
// Controller: accepts transactions, sequences seed expansion, owns out valid.
// ----------------------------------------------------------------------------
module xs128_ctrl
    import xs128_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       operation,
    output logic       out_valid,
    input  logic       out_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    state_t     state_reg, state_next;
    logic [1:0] idx_reg, idx_next;
    logic       pass_reg, pass_next;
    logic       out_valid_reg, out_valid_next;
    logic       in_accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= 2'd0;
            pass_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            pass_reg      <= pass_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        pass_next      = pass_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.key_idx    = idx_reg;
        in_ready       = 1'b0;
        in_accept      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready  = !out_valid_reg || out_ready;
                in_accept = in_valid && in_ready;
                if (in_accept)
                begin
                    if (operation == OP_RESEED)
                    begin
                        cmd.load_seed = 1'b1;
                        idx_next      = 2'd0;
                        pass_next     = 1'b0;
                        state_next    = ST_MUL;
                    end
                    else
                    begin
                        cmd.next_en    = 1'b1;
                        out_valid_next = 1'b1;
                    end
                end
            end
            ST_MUL:
            begin
                cmd.mul_en = 1'b1;
                state_next = ST_MIX;
            end
            ST_MIX:
            begin
                cmd.mix_en = 1'b1;
                idx_next   = idx_reg + 2'd1;
                if (idx_reg == LAST_WORD_IDX)
                begin
                    if (status.all_zero && !pass_reg)
                    begin
                        pass_next  = 1'b1;
                        state_next = ST_MUL;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    state_next = ST_MUL;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

### rtl/core/xs128_dp.sv
// ----------------------------------------------------------------------------
// xs128_dp
// Datapath: the four state words, the seed scrambler and the output register.
// ----------------------------------------------------------------------------
module xs128_dp
    import xs128_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  dp_cmd_t           cmd,
    input  logic [WORD_W-1:0] seed_value,
    output dp_status_t        status,
    output logic [WORD_W-1:0] random_word
);

    logic [WORD_W-1:0] word_a_reg, word_b_reg, word_c_reg, word_d_reg;
    logic [WORD_W-1:0] seed_reg, seed_next;
    logic [WORD_W-1:0] prod_reg, prod_next;
    logic [WORD_W-1:0] random_word_reg;
    logic [WORD_W-1:0] mix_val;
    logic [WORD_W-1:0] seed_word;
    logic [WORD_W-1:0] tmp_word;
    logic [WORD_W-1:0] next_word;

    assign prod_next = seed_reg * SEED_MULT + 32'd1;
    assign mix_val   = seed_mix(prod_reg);
    assign seed_word = seed_key(cmd.key_idx) ^ mix_val;
    assign tmp_word  = word_a_reg ^ (word_a_reg << 11);
    assign next_word = word_d_reg ^ (word_d_reg >> 19) ^ tmp_word ^ (tmp_word >> 8);
    assign seed_next = cmd.load_seed ? seed_value : mix_val;

    assign status.all_zero = (word_b_reg == '0) && (word_c_reg == '0)
                          && (word_d_reg == '0) && (seed_word == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_a_reg <= RESET_WORD_A;
            word_b_reg <= RESET_WORD_B;
            word_c_reg <= RESET_WORD_C;
            word_d_reg <= RESET_WORD_D;
        end
        else if (cmd.next_en || cmd.mix_en)
        begin
            word_a_reg <= word_b_reg;
            word_b_reg <= word_c_reg;
            word_c_reg <= word_d_reg;
            word_d_reg <= cmd.next_en ? next_word : seed_word;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_seed || cmd.mix_en)
        begin
            seed_reg <= seed_next;
        end
        if (cmd.mul_en)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.next_en)
        begin
            random_word_reg <= next_word;
        end
    end

    assign random_word = random_word_reg;

endmodule
